FILE: src/nclpf_pkg.sv
// ----------------------------------------------------------------------------
// nclpf_pkg
// Shared codes, characters, helper functions and controller/datapath
// command and status types for the command-line PGN filter.
// ----------------------------------------------------------------------------
package nclpf_pkg;

   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_PGN  = 2'd1;
   localparam logic [1:0] ACT_SENT = 2'd2;

   localparam logic [2:0] OUT_NONE  = 3'd0;
   localparam logic [2:0] OUT_SET   = 3'd1;
   localparam logic [2:0] OUT_BAD   = 3'd2;
   localparam logic [2:0] OUT_CSUM  = 3'd3;
   localparam logic [2:0] OUT_QUERY = 3'd4;

   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7e;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_DOLL  = 8'h24;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int PREFIX_LEN = 7;

   typedef struct packed {
      logic take;
      logic fetch;
      logic proc;
      logic fin;
      logic q_read;
      logic q_cmp;
      logic q_done;
   } cmd_type;

   typedef struct packed {
      logic need_walk;
      logic need_query;
      logic walk_stop;
      logic q_stop;
      logic rsp_free;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = 8'h30 + {4'h0, n};
      end else begin
         r = 8'h37 + {4'h0, n};
      end
      return r;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0:    r = 8'h24;
         3'd1:    r = 8'h50;
         3'd2:    r = 8'h43;
         3'd3:    r = 8'h44;
         3'd4:    r = 8'h43;
         3'd5:    r = 8'h4d;
         default: r = 8'h2c;
      endcase
      return r;
   endfunction

endpackage

FILE: src/nclpf_ctrl.sv
// ----------------------------------------------------------------------------
// nclpf_ctrl
// Sequencer: takes items, steps the line walk and the filter list search,
// and waits for the output register before loading a long result.
// ----------------------------------------------------------------------------
module nclpf_ctrl
   import nclpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FETCH = 7'b0000010,
      ST_PROC  = 7'b0000100,
      ST_FIN   = 7'b0001000,
      ST_QREAD = 7'b0010000,
      ST_QCMP  = 7'b0100000,
      ST_QRSP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = !((state_ff == ST_IDLE) && status.rsp_free);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid && status.rsp_free;
            if (cmd.take && status.need_walk) begin
               state_in = ST_FETCH;
            end else if (cmd.take && status.need_query) begin
               state_in = ST_QREAD;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_PROC;
         end
         ST_PROC: begin
            cmd.proc = 1'b1;
            state_in = status.walk_stop ? ST_FIN : ST_FETCH;
         end
         ST_FIN: begin
            cmd.fin = status.rsp_free;
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_QREAD: begin
            cmd.q_read = 1'b1;
            state_in   = ST_QCMP;
         end
         ST_QCMP: begin
            cmd.q_cmp = 1'b1;
            state_in  = status.q_stop ? ST_QRSP : ST_QREAD;
         end
         ST_QRSP: begin
            cmd.q_done = status.rsp_free;
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/nclpf_dp.sv
// ----------------------------------------------------------------------------
// nclpf_dp
// Datapath: line memory with running checksum and prefix match, field
// parser, filter list memory, counters and the output register.
// ----------------------------------------------------------------------------
module nclpf_dp
   import nclpf_pkg::*;
#(
   parameter int LINE_BYTES   = 256,
   parameter int FILTER_DEPTH = 16,
   parameter int UW           = $clog2(FILTER_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output status_type    status,
   input  logic [1:0]    req_action,
   input  logic [7:0]    req_rx_byte,
   input  logic [17:0]   req_pgn,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    rsp_outcome,
   output logic          rsp_accept,
   output logic          rsp_filtered_mode,
   output logic [UW-1:0] rsp_filter_count,
   output logic [31:0]   rsp_received_count,
   output logic [31:0]   rsp_bad_command_count,
   output logic [31:0]   rsp_checksum_error_count,
   output logic [31:0]   rsp_sent_count
);

   localparam int LW  = $clog2(LINE_BYTES);
   localparam int FIW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam logic [LW-1:0] LEN_MAX = LW'(LINE_BYTES - 2);
   localparam logic [UW-1:0] USED_MAX = UW'(FILTER_DEPTH);

   typedef enum logic [2:0] {
      FS_SKIP = 3'b001,
      FS_DIG  = 3'b010,
      FS_DONE = 3'b100
   } fstate_type;

   // line memory and running line status
   logic [7:0]    line_mem [LINE_BYTES];
   logic [7:0]    rd_line_ff;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic          stop_ff, stop_in, star_ff, star_in, pmatch_ff, pmatch_in;
   logic [1:0]    post_ff, post_in;
   logic [7:0]    c1_ff, c1_in, c2_ff, c2_in;
   logic          store, line_clr, is_nl, csum_ok, prefix_ok;

   // walk
   logic [LW-1:0] ptr_ff, ptr_in;
   fstate_type    fst_ff, fst_in;
   logic          neg_ff, neg_in, first_done_ff, first_done_in, abort_ff, abort_in;
   logic [31:0]   val_ff, val_in, fval;
   logic          fz, first_bad;
   logic [7:0]    ch;
   logic [31:0]   dval;

   // filter list
   logic [31:0]   filt_mem [FILTER_DEPTH];
   logic [31:0]   rd_filt_ff;
   logic [UW-1:0] used_ff, used_in, qidx_ff, qidx_in;
   logic          fwr;
   logic          hit_ff, hit_in, hit;
   logic [17:0]   pgn_ff;
   logic          mode_ff, mode_in;

   // counters and output
   logic [31:0]   good_ff, good_in, badc_ff, badc_in, badcs_ff, badcs_in, fwd_ff, fwd_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_load, rsp_free;
   logic [2:0]    outcome_in;
   logic          accept_in;
   logic [2:0]    rsp_outcome_ff;
   logic          rsp_accept_ff, rsp_mode_ff;
   logic [UW-1:0] rsp_used_ff;
   logic [31:0]   rsp_good_ff, rsp_badc_ff, rsp_badcs_ff, rsp_fwd_ff;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign is_nl     = (req_action == ACT_BYTE) && (req_rx_byte == CH_NL);
   assign csum_ok   = stop_ff && star_ff && (post_ff == 2'd2) &&
                      (c1_ff == hex_char(sum_ff[7:4])) && (c2_ff == hex_char(sum_ff[3:0]));
   assign prefix_ok = pmatch_ff && (len_ff >= LW'(PREFIX_LEN));

   assign status.need_walk  = is_nl && csum_ok && prefix_ok;
   assign status.need_query = (req_action == ACT_PGN) && mode_ff && (used_ff != '0);
   assign status.rsp_free   = rsp_free;

   assign ch   = rd_line_ff;
   assign fval = neg_ff ? (32'd0 - val_ff) : val_ff;
   assign dval = {24'd0, ch - CH_ZERO};
   assign fz   = !abort_ff && ((cmd.proc && (ch == CH_COMMA)) || cmd.fin);
   assign first_bad = fz && !first_done_ff && (fval != 32'd1);
   assign status.walk_stop = cmd.proc &&
                             ((({1'b0, ptr_ff} + 1'b1) == {1'b0, len_ff}) || first_bad);

   assign hit = (rd_filt_ff == {14'd0, pgn_ff});
   assign status.q_stop = hit || ((qidx_ff + 1'b1) >= used_ff);

   // running checksum, prefix match and byte store
   always_comb begin
      store = cmd.take && (req_action == ACT_BYTE) && (req_rx_byte != CH_NL) &&
              (req_rx_byte inside {[CH_SPACE:CH_TILDE]}) && (len_ff < LEN_MAX);
      line_clr = (cmd.take && is_nl && !status.need_walk) || cmd.fin;
      len_in    = len_ff;
      sum_in    = sum_ff;
      stop_in   = stop_ff;
      star_in   = star_ff;
      post_in   = post_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      pmatch_in = pmatch_ff;
      if (line_clr) begin
         len_in    = '0;
         sum_in    = '0;
         stop_in   = 1'b0;
         star_in   = 1'b0;
         post_in   = '0;
         pmatch_in = 1'b1;
      end else if (store) begin
         len_in = len_ff + 1'b1;
         if ((len_ff < LW'(PREFIX_LEN)) && (req_rx_byte != prefix_char(len_ff[2:0]))) begin
            pmatch_in = 1'b0;
         end
         if (len_ff != '0) begin
            if (!stop_ff) begin
               if ((req_rx_byte == CH_STAR) || (req_rx_byte == CH_DOLL)) begin
                  stop_in = 1'b1;
                  star_in = (req_rx_byte == CH_STAR);
               end else begin
                  sum_in = sum_ff ^ req_rx_byte;
               end
            end else begin
               if (post_ff == 2'd0) begin
                  c1_in = req_rx_byte;
               end
               if (post_ff == 2'd1) begin
                  c2_in = req_rx_byte;
               end
               if (post_ff != 2'd3) begin
                  post_in = post_ff + 1'b1;
               end
            end
         end
      end
   end

   // field parser and filter list update
   always_comb begin
      ptr_in        = ptr_ff;
      fst_in        = fst_ff;
      neg_in        = neg_ff;
      val_in        = val_ff;
      first_done_in = first_done_ff;
      abort_in      = abort_ff;
      used_in       = used_ff;
      fwr           = 1'b0;
      if (cmd.take && status.need_walk) begin
         ptr_in        = LW'(PREFIX_LEN);
         fst_in        = FS_SKIP;
         neg_in        = 1'b0;
         val_in        = '0;
         first_done_in = 1'b0;
         abort_in      = 1'b0;
      end
      if (cmd.proc) begin
         ptr_in = ptr_ff + 1'b1;
         if (ch == CH_COMMA) begin
            fst_in = FS_SKIP;
            neg_in = 1'b0;
            val_in = '0;
         end else begin
            case (fst_ff)
               FS_SKIP: begin
                  if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
                     neg_in = (ch == CH_MINUS);
                     fst_in = FS_DIG;
                  end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
                     val_in = dval;
                     fst_in = FS_DIG;
                  end else if (ch != CH_SPACE) begin
                     fst_in = FS_DONE;
                  end
               end
               FS_DIG: begin
                  if (ch inside {[CH_ZERO:CH_NINE]}) begin
                     val_in = (val_ff << 3) + (val_ff << 1) + dval;
                  end else begin
                     fst_in = FS_DONE;
                  end
               end
               default: begin
                  fst_in = FS_DONE;
               end
            endcase
         end
      end
      if (fz) begin
         if (!first_done_ff) begin
            if (first_bad) begin
               abort_in = 1'b1;
            end else begin
               first_done_in = 1'b1;
               used_in       = '0;
            end
         end else if (used_ff < USED_MAX) begin
            fwr     = 1'b1;
            used_in = used_ff + 1'b1;
         end
      end
   end

   always_comb begin
      qidx_in = qidx_ff;
      hit_in  = hit_ff;
      if (cmd.take) begin
         qidx_in = '0;
         hit_in  = 1'b0;
      end else if (cmd.q_cmp) begin
         qidx_in = qidx_ff + 1'b1;
         hit_in  = hit;
      end
   end

   // counters and result selection
   always_comb begin
      good_in    = good_ff;
      badc_in    = badc_ff;
      badcs_in   = badcs_ff;
      fwd_in     = fwd_ff;
      mode_in    = mode_ff;
      outcome_in = OUT_NONE;
      accept_in  = 1'b0;
      rsp_load   = 1'b0;
      if (cmd.take) begin
         rsp_load = !status.need_walk && !status.need_query;
         case (req_action)
            ACT_BYTE: begin
               if (is_nl) begin
                  if (!csum_ok) begin
                     badcs_in   = badcs_ff + 1'b1;
                     outcome_in = OUT_CSUM;
                  end else begin
                     good_in = good_ff + 1'b1;
                     if (prefix_ok) begin
                        mode_in = 1'b1;
                     end else begin
                        badc_in    = badc_ff + 1'b1;
                        outcome_in = OUT_BAD;
                     end
                  end
               end
            end
            ACT_PGN: begin
               outcome_in = OUT_QUERY;
            end
            ACT_SENT: begin
               outcome_in = OUT_QUERY;
               accept_in  = !mode_ff;
               if (!mode_ff) begin
                  fwd_in = fwd_ff + 1'b1;
               end
            end
            default: begin
               outcome_in = OUT_NONE;
            end
         endcase
      end
      if (cmd.fin) begin
         rsp_load = 1'b1;
         if (abort_ff || first_bad) begin
            badc_in    = badc_ff + 1'b1;
            outcome_in = OUT_BAD;
         end else begin
            outcome_in = OUT_SET;
         end
      end
      if (cmd.q_done) begin
         rsp_load   = 1'b1;
         outcome_in = OUT_QUERY;
         accept_in  = hit_ff;
         if (hit_ff) begin
            fwd_in = fwd_ff + 1'b1;
         end
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (store) begin
         line_mem[len_ff] <= req_rx_byte;
      end
      if (cmd.fetch) begin
         rd_line_ff <= line_mem[ptr_ff];
      end
      if (fwr) begin
         filt_mem[used_ff[FIW-1:0]] <= fval;
      end
      if (cmd.q_read) begin
         rd_filt_ff <= filt_mem[qidx_ff[FIW-1:0]];
      end
      if (cmd.take) begin
         pgn_ff <= req_pgn;
      end
      c1_ff  <= c1_in;
      c2_ff  <= c2_in;
      val_ff <= val_in;
      neg_ff <= neg_in;
      ptr_ff <= ptr_in;
      if (rsp_load) begin
         rsp_outcome_ff <= outcome_in;
         rsp_accept_ff  <= accept_in;
         rsp_mode_ff    <= mode_in;
         rsp_used_ff    <= used_in;
         rsp_good_ff    <= good_in;
         rsp_badc_ff    <= badc_in;
         rsp_badcs_ff   <= badcs_in;
         rsp_fwd_ff     <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         sum_ff        <= '0;
         stop_ff       <= 1'b0;
         star_ff       <= 1'b0;
         post_ff       <= '0;
         pmatch_ff     <= 1'b1;
         fst_ff        <= FS_SKIP;
         first_done_ff <= 1'b0;
         abort_ff      <= 1'b0;
         used_ff       <= '0;
         qidx_ff       <= '0;
         hit_ff        <= 1'b0;
         mode_ff       <= 1'b0;
         good_ff       <= '0;
         badc_ff       <= '0;
         badcs_ff      <= '0;
         fwd_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         sum_ff        <= sum_in;
         stop_ff       <= stop_in;
         star_ff       <= star_in;
         post_ff       <= post_in;
         pmatch_ff     <= pmatch_in;
         fst_ff        <= fst_in;
         first_done_ff <= first_done_in;
         abort_ff      <= abort_in;
         used_ff       <= used_in;
         qidx_ff       <= qidx_in;
         hit_ff        <= hit_in;
         mode_ff       <= mode_in;
         good_ff       <= good_in;
         badc_ff       <= badc_in;
         badcs_ff      <= badcs_in;
         fwd_ff        <= fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_outcome              = rsp_outcome_ff;
   assign rsp_accept               = rsp_accept_ff;
   assign rsp_filtered_mode        = rsp_mode_ff;
   assign rsp_filter_count         = rsp_used_ff;
   assign rsp_received_count       = rsp_good_ff;
   assign rsp_bad_command_count    = rsp_badc_ff;
   assign rsp_checksum_error_count = rsp_badcs_ff;
   assign rsp_sent_count           = rsp_fwd_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_MAX)
      else $error("filter count above list depth");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("line length above limit");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result loaded while output register busy");

   a_csum_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && is_nl && !csum_ok) |=> (badcs_ff == $past(badcs_ff) + 32'd1))
      else $error("checksum error not counted");
`endif

endmodule

FILE: src/nmea_command_line_pgn_filter.sv
// Timing: a stored or dropped byte, a plain sentence query and a rejected line give
//   their result in the cycle after the transfer; a $PCDCM command line walks the line
//   memory after the prefix with a fetch and a process step per byte, a PGN query reads
//   and compares the filter entries one by one. One item is in work at a time.
// Reset: synchronous, active high; counters, mode and list count clear, memories do not.
// ----------------------------------------------------------------------------
// nmea_command_line_pgn_filter
// Client command-line receiver: checksum check, PGN filter list update and
// forwarding decisions for PGN and plain sentence queries.
// ----------------------------------------------------------------------------
module nmea_command_line_pgn_filter
   import nclpf_pkg::*;
#(
   parameter int LINE_BYTES   = 256,
   parameter int FILTER_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_action,
   input  logic [7:0]                         req_rx_byte,
   input  logic [17:0]                        req_pgn,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_outcome,
   output logic                               rsp_accept,
   output logic                               rsp_filtered_mode,
   output logic [$clog2(FILTER_DEPTH+1)-1:0]  rsp_filter_count,
   output logic [31:0]                        rsp_received_count,
   output logic [31:0]                        rsp_bad_command_count,
   output logic [31:0]                        rsp_checksum_error_count,
   output logic [31:0]                        rsp_sent_count
);

   cmd_type    cmd;
   status_type status;

   nclpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nclpf_dp #(
      .LINE_BYTES   (LINE_BYTES),
      .FILTER_DEPTH (FILTER_DEPTH),
      .UW           ($clog2(FILTER_DEPTH + 1))
   ) u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .req_action               (req_action),
      .req_rx_byte              (req_rx_byte),
      .req_pgn                  (req_pgn),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_outcome              (rsp_outcome),
      .rsp_accept               (rsp_accept),
      .rsp_filtered_mode        (rsp_filtered_mode),
      .rsp_filter_count         (rsp_filter_count),
      .rsp_received_count       (rsp_received_count),
      .rsp_bad_command_count    (rsp_bad_command_count),
      .rsp_checksum_error_count (rsp_checksum_error_count),
      .rsp_sent_count           (rsp_sent_count)
   );

endmodule

FILE: sim/nmea_command_line_pgn_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_command_line_pgn_filter_tb
// Self-checking bench for the command-line PGN filter: drives bytes and
// forwarding queries, predicts every response and compares all fields.
// ----------------------------------------------------------------------------
module nmea_command_line_pgn_filter_tb;
   import nclpf_pkg::*;

   localparam int LINE_MAX  = 256;
   localparam int LIST_MAX  = 16;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  rx_byte;
      logic [17:0] pgn;
   } req_t;

   typedef struct packed {
      logic [2:0]  outcome;
      logic        accept;
      logic        filtered_mode;
      logic [4:0]  filter_count;
      logic [31:0] received_count;
      logic [31:0] bad_command_count;
      logic [31:0] checksum_error_count;
      logic [31:0] sent_count;
   } rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic [17:0] req_pgn = 18'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_outcome;
   logic        rsp_accept;
   logic        rsp_filtered_mode;
   logic [4:0]  rsp_filter_count;
   logic [31:0] rsp_received_count;
   logic [31:0] rsp_bad_command_count;
   logic [31:0] rsp_checksum_error_count;
   logic [31:0] rsp_sent_count;

   nmea_command_line_pgn_filter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_rx_byte(req_rx_byte), .req_pgn(req_pgn),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_outcome(rsp_outcome),
      .rsp_accept(rsp_accept), .rsp_filtered_mode(rsp_filtered_mode),
      .rsp_filter_count(rsp_filter_count), .rsp_received_count(rsp_received_count),
      .rsp_bad_command_count(rsp_bad_command_count),
      .rsp_checksum_error_count(rsp_checksum_error_count),
      .rsp_sent_count(rsp_sent_count)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [7:0]  line_buf [LINE_MAX];
   int unsigned line_len;
   logic        mode_flt;
   logic [31:0] pgn_list [LIST_MAX];
   int unsigned list_used;
   logic [31:0] n_good, n_badcmd, n_badsum, n_sent;

   rsp_t expected_rsps[$];
   int   mismatches = 0;
   int   rsp_seen = 0;
   int   lines_sent = 0;
   int   items_sent = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;

   function automatic logic [7:0] hex_of(input logic [3:0] n);
      return (n < 10) ? 8'h30 + n : 8'h37 + n;
   endfunction

   function automatic logic sum_ok();
      int unsigned i;
      logic [7:0] x;
      i = 1;
      x = 8'h00;
      while (i < line_len && line_buf[i] != CH_STAR && line_buf[i] != CH_DOLL) begin
         x ^= line_buf[i];
         i++;
      end
      if (i >= line_len || line_buf[i] != CH_STAR) return 1'b0;
      if (i + 3 != line_len) return 1'b0;
      return line_buf[i+1] == hex_of(x[7:4]) && line_buf[i+2] == hex_of(x[3:0]);
   endfunction

   function automatic logic [31:0] atol_at(input int unsigned p);
      logic [31:0] v;
      logic neg;
      v = 0;
      neg = 1'b0;
      while (p < line_len && line_buf[p] == CH_SPACE) p++;
      if (p < line_len && (line_buf[p] == CH_PLUS || line_buf[p] == CH_MINUS)) begin
         neg = line_buf[p] == CH_MINUS;
         p++;
      end
      while (p < line_len && line_buf[p] >= CH_ZERO && line_buf[p] <= CH_NINE) begin
         v = v * 32'd10 + 32'(line_buf[p] - CH_ZERO);
         p++;
      end
      return neg ? 32'd0 - v : v;
   endfunction

   function automatic logic [2:0] run_command();
      int unsigned p;
      logic first;
      logic [7:0] pfx [7];
      pfx = '{"$", "P", "C", "D", "C", "M", ","};
      if (!sum_ok()) begin
         n_badsum++;
         return OUT_CSUM;
      end
      n_good++;
      if (line_len < 7) begin
         n_badcmd++;
         return OUT_BAD;
      end
      for (int k = 0; k < 7; k++) begin
         if (line_buf[k] != pfx[k]) begin
            n_badcmd++;
            return OUT_BAD;
         end
      end
      mode_flt = 1'b1;
      first = 1'b1;
      for (p = 0; p < line_len; p++) begin
         if (line_buf[p] == CH_COMMA) begin
            if (first) begin
               if (atol_at(p + 1) != 32'd1) begin
                  n_badcmd++;
                  return OUT_BAD;
               end
               list_used = 0;
               first = 1'b0;
            end else if (list_used < LIST_MAX) begin
               pgn_list[list_used] = atol_at(p + 1);
               list_used++;
            end
         end
      end
      return first ? OUT_NONE : OUT_SET;
   endfunction

   function automatic rsp_t filter_step(input req_t r);
      rsp_t o;
      o = '0;
      if (r.action == ACT_BYTE) begin
         if (r.rx_byte == CH_NL) begin
            o.outcome = run_command();
            line_len = 0;
         end else if (r.rx_byte >= CH_SPACE && r.rx_byte <= CH_TILDE
                      && line_len < LINE_MAX - 2) begin
            line_buf[line_len] = r.rx_byte;
            line_len++;
         end
      end else if (r.action == ACT_PGN) begin
         o.outcome = OUT_QUERY;
         if (mode_flt) begin
            for (int k = 0; k < list_used; k++) begin
               if (pgn_list[k] == {14'h0, r.pgn}) o.accept = 1'b1;
            end
         end
         if (o.accept) n_sent++;
      end else if (r.action == ACT_SENT) begin
         o.outcome = OUT_QUERY;
         o.accept = !mode_flt;
         if (o.accept) n_sent++;
      end
      o.filtered_mode = mode_flt;
      o.filter_count = 5'(list_used);
      o.received_count = n_good;
      o.bad_command_count = n_badcmd;
      o.checksum_error_count = n_badsum;
      o.sent_count = n_sent;
      return o;
   endfunction

   // one transfer; valid stays up after acceptance unless the sender idles
   task automatic send_item(input req_t r);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= r.action;
      req_rx_byte <= r.rx_byte;
      req_pgn     <= r.pgn;
      expected_rsps = {expected_rsps, filter_step(r)};
      items_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item('{ACT_BYTE, b, 18'h0});
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_byte(s[k]);
   endtask

   // body plus checksum (corrupted when good is low) and newline
   task automatic send_line(input string body, input logic good);
      logic [7:0] x;
      x = 8'h00;
      for (int k = 1; k < body.len(); k++) x ^= body[k];
      if (!good) x ^= 8'h01 << $urandom_range(7);
      send_text(body);
      send_byte(CH_STAR);
      send_byte(hex_of(x[7:4]));
      send_byte(hex_of(x[3:0]));
      send_byte(CH_NL);
      lines_sent++;
   endtask

   // response check
   always @(posedge clock) begin
      rsp_t got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_outcome, rsp_accept, rsp_filtered_mode, rsp_filter_count,
                    rsp_received_count, rsp_bad_command_count,
                    rsp_checksum_error_count, rsp_sent_count};
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at response %0d: expected %h got %h",
                              rsp_seen, want, got);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic string rand_digits(input int n);
      string s;
      s = "";
      for (int k = 0; k < n; k++) s = {s, string'(8'(8'h30 + $urandom_range(9)))};
      return s;
   endfunction

   function automatic string rand_field();
      string s;
      case ($urandom_range(5))
         0: s = "";
         1: s = {" -", rand_digits($urandom_range(1, 3))};
         2: s = {"+", rand_digits(12)};
         3: s = $sformatf("%0d", $urandom_range(262143));
         default: s = $sformatf("%0d", $urandom_range(130000, 130010));
      endcase
      return s;
   endfunction

   req_t directed [] = '{
      '{ACT_PGN,  8'h00, 18'h3ffff},
      '{ACT_SENT, 8'h00, 18'h0},
      '{2'd3,     8'hff, 18'h0},
      '{ACT_BYTE, 8'h00, 18'h0},
      '{ACT_BYTE, 8'h1f, 18'h0},
      '{ACT_BYTE, 8'h7f, 18'h0},
      '{ACT_BYTE, 8'hff, 18'h0},
      '{ACT_BYTE, CH_NL, 18'h0}
   };
   // first three typed directly: plain mode answers, only the plain sentence query counted as sent
   rsp_t directed_want [3] = '{
      '{OUT_QUERY, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0, 32'd0, 32'd0},
      '{OUT_QUERY, 1'b1, 1'b0, 5'd0, 32'd0, 32'd0, 32'd0, 32'd1},
      '{OUT_NONE,  1'b0, 1'b0, 5'd0, 32'd0, 32'd0, 32'd0, 32'd1}
   };

   initial begin
      string s;
      int target;
      line_len = 0; mode_flt = 0; list_used = 0;
      n_good = 0; n_badcmd = 0; n_badsum = 0; n_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (i < 3) begin
            rsp_t p;
            p = filter_step(directed[i]);
            if (p !== directed_want[i]) begin
               mismatches++;
               $display("directed row %0d disagrees with typed value", i);
            end
            // undo predictor update, send_item applies it again
            if (directed[i].action == ACT_SENT) n_sent--;
         end
         send_item(directed[i]);
      end
      send_line("$PCDCM,1,127488,-1,+4294967297, 60928", 1'b1);
      send_item('{ACT_PGN, 8'h00, 18'd127488});
      send_item('{ACT_PGN, 8'h00, 18'd60928});
      send_item('{ACT_SENT, 8'h00, 18'h0});
      send_line("$PCDCM,2", 1'b1);
      send_line("$GPGGA,1", 1'b1);
      send_line("$PCDCM,1,5", 1'b0);
      send_line("$PCDCM", 1'b1);
      // overlong line: fills the store, then the tail is dropped
      for (int k = 0; k < 260; k++) send_byte(8'(8'h41 + $urandom_range(25)));
      send_line("$PCDCM,1,7", 1'b1);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 88; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 88; end
            3: begin idle_pct = 25; stall_pct = 25; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         target = items_sent + 105;
         while (items_sent < target) begin
            case ($urandom_range(9))
               0, 1, 2: begin
                  s = $urandom_range(3) == 0 ? "$PCDCM,1" : "$PCDCM,";
                  if (s == "$PCDCM,") s = {s, rand_field()};
                  for (int f = $urandom_range(4); f > 0; f--) s = {s, ",", rand_field()};
                  send_line(s, $urandom_range(5) != 0);
               end
               3: send_line({"$GP", rand_digits(3), ",", rand_field()},
                            $urandom_range(1) == 1);
               4: send_line("$PCDCM,1,7", 1'b1);
               5: send_byte(8'($urandom_range(255)));
               6: send_item('{ACT_SENT, 8'($urandom), 18'($urandom)});
               7: send_item('{2'($urandom), 8'($urandom), 18'($urandom)});
               default: send_item('{ACT_PGN, 8'h00,
                                    $urandom_range(1) ? 18'($urandom_range(130000, 130010))
                                                      : 18'($urandom)});
            endcase
         end
         // drop valid, then drain; longest walk is a full line, fetched and processed byte by byte
         req_valid <= 1'b0;
         while (expected_rsps.size() != 0) @(posedge clock);
         repeat (600) @(posedge clock);
      end
      stall_pct = 0;
      repeat (600) @(posedge clock);
      $display("covered %0d items, %0d responses, %0d checksummed lines",
               items_sent, rsp_seen, lines_sent);
      $display("five idle/stall phases, overlong line and out-of-range bytes included");
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("mismatches %0d, left over %0d", mismatches, expected_rsps.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
